// ===== rtl/blf_pkg.sv =====
// ----------------------------------------------------------------------------
// blf_pkg: shared types and constants for the battery level filter
// Register indexes, status and event codes, divider widths and the
// request record that the sequencer hands to the serial divider.
// ----------------------------------------------------------------------------
package blf_pkg;

	localparam int unsigned DIV_W = 24;   // dividend / quotient width
	localparam int unsigned DVS_W = 16;   // divisor / remainder width
	localparam int unsigned CNT_W = $clog2(DIV_W);

	localparam int unsigned PCT_W   = 7;
	localparam int unsigned VOLT_W  = 16;
	localparam int unsigned COUNT_W = 32;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	localparam logic [2:0] REG_VALID_MIN   = 3'd0;
	localparam logic [2:0] REG_VALID_MAX   = 3'd1;
	localparam logic [2:0] REG_EMPTY_LEVEL = 3'd2;
	localparam logic [2:0] REG_FULL_LEVEL  = 3'd3;
	localparam logic [2:0] REG_HYST_PCT    = 3'd4;
	localparam logic [2:0] REG_ERROR_LIMIT = 3'd5;

	localparam logic [1:0] STATUS_SEARCH = 2'd0;
	localparam logic [1:0] STATUS_READY  = 2'd1;
	localparam logic [1:0] STATUS_ERROR  = 2'd2;

	localparam logic [1:0] EVENT_NONE  = 2'd0;
	localparam logic [1:0] EVENT_START = 2'd1;
	localparam logic [1:0] EVENT_END   = 2'd2;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

endpackage

// ===== rtl/battery_level_filter_hysteresis_unit.sv =====
// ----------------------------------------------------------------------------
// battery_level_filter_hysteresis_unit: battery voltage filter and display
// Rounded IIR low-pass on accepted samples, linear percent mapping with
// hysteresis, error counting and charger edge events.
// ----------------------------------------------------------------------------
// One result per sample. A rejected sample goes from S_IDLE straight to S_FIN.
// An accepted sample updates the filter by a reciprocal multiplication in
// S_FDIV. When the filtered voltage falls strictly between the empty and full
// levels, the percent then goes through the serial divider in S_PSET and
// S_PDIV. The first sample only seeds the filter and skips S_FDIV. A sample
// that clamps to 0 or 100 goes from S_PSET straight to S_FIN. The input is
// not ready while a sample is in work. A finished result sits in the output
// register, so the next sample can be taken while it waits.
// FILTER_DIVISOR ranges 2 to 16.
module battery_level_filter_hysteresis_unit #(
	parameter int unsigned FILTER_DIVISOR = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] voltage_sample, [16] external_power, [17] charge_full, [23:18] zero
	input  logic [23:0] s_tdata,
	// [0] read_ok, [1] charge_valid
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] filtered_voltage, [22:16] shown_percent, [24:23] service_status,
	// [26:25] charge_event, [27] ext_power_out, [28] full_out,
	// [60:29] adc_errors, [92:61] charge_errors, [95:93] zero
	output logic [95:0] m_tdata,
	// [0] sample_taken
	output logic [0:0]  m_tuser
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FDIV = 3'd1;
	localparam logic [2:0] S_PSET = 3'd2;
	localparam logic [2:0] S_PDIV = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	localparam int unsigned DW = blf_pkg::DIV_W;
	localparam int unsigned VW = blf_pkg::VOLT_W;
	localparam int unsigned PW = blf_pkg::PCT_W;
	localparam int unsigned CW = blf_pkg::COUNT_W;

	// filter sum f*(D-1) + v + D/2 stays below 2^20 for D up to 16;
	// divide it by D as (sum * REC_MUL) >> REC_SH, exact over that range
	localparam int unsigned ACC_W  = 20;
	localparam int unsigned REC_SH = ACC_W + $clog2(FILTER_DIVISOR);
	localparam int unsigned REC_W  = 22;
	localparam int unsigned PROD_W = ACC_W + REC_W;
	localparam logic [REC_W-1:0] REC_MUL =
		REC_W'((2**REC_SH + FILTER_DIVISOR - 1) / FILTER_DIVISOR);

	// configuration
	logic [VW-1:0] valid_min_q, valid_max_q, empty_level_q, full_level_q;
	logic [PW-1:0] hyst_pct_q;
	logic [7:0]    error_limit_q;

	// block state
	logic [2:0]    state_q;
	logic [VW-1:0] filter_q;
	logic [PW-1:0] disp_q;
	logic          primed_q;
	logic [CW-1:0] consec_q, adc_err_q, chg_err_q;
	logic [1:0]    status_q;
	logic          prev_ext_q, ext_held_q, full_held_q;

	// item in work
	logic [ACC_W-1:0] acc_q;
	logic          taken_q, cvalid_q, ext_q, full_q;
	logic [VW-1:0] filt_new_q;
	logic [PW-1:0] cand_q;

	// output register
	logic          m_tvalid_q;
	logic [95:0]   m_tdata_q;
	logic [0:0]    m_tuser_q;

	blf_pkg::div_req_t     div_req;
	logic                  div_done;
	logic [DW-1:0]         div_quo;

	logic                  in_fire, fin_fire, in_taken;
	logic [VW-1:0]         in_volt;
	logic [PW-1:0]         diff, disp_next;
	logic [CW-1:0]         consec_next;
	logic [1:0]            event_next;
	logic [PROD_W-1:0]     filt_prod;

	assign s_tready = state_q == S_IDLE;
	assign in_fire  = s_tvalid && s_tready;
	assign fin_fire = state_q == S_FIN && (!m_tvalid_q || m_tready);
	assign in_volt  = s_tdata[15:0];
	assign in_taken = s_tuser[0] && in_volt >= valid_min_q && in_volt <= valid_max_q;

	assign filt_prod = PROD_W'(acc_q) * PROD_W'(REC_MUL);

	blf_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// divider requests: percent in S_PSET
	always_comb begin
		div_req = '0;
		if (state_q == S_PSET) begin
			div_req.start    = filt_new_q > empty_level_q && filt_new_q < full_level_q;
			div_req.dividend = DW'(filt_new_q - empty_level_q) * DW'(blf_pkg::PCT_FULL);
			div_req.divisor  = full_level_q - empty_level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_min_q   <= 16'd25000;
			valid_max_q   <= 16'd48000;
			empty_level_q <= 16'd33000;
			full_level_q  <= 16'd41000;
			hyst_pct_q    <= 7'd2;
			error_limit_q <= 8'd3;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				blf_pkg::REG_VALID_MIN:   valid_min_q   <= cfg_data;
				blf_pkg::REG_VALID_MAX:   valid_max_q   <= cfg_data;
				blf_pkg::REG_EMPTY_LEVEL: empty_level_q <= cfg_data;
				blf_pkg::REG_FULL_LEVEL:  full_level_q  <= cfg_data;
				blf_pkg::REG_HYST_PCT:    hyst_pct_q    <= cfg_data[PW-1:0];
				blf_pkg::REG_ERROR_LIMIT: error_limit_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (!in_taken) state_q <= S_FIN;
						else if (primed_q) state_q <= S_FDIV;
						else state_q <= S_PSET;
					end
				end
				S_FDIV: state_q <= S_PSET;
				S_PSET: state_q <= div_req.start ? S_PDIV : S_FIN;
				S_PDIV: if (div_done) state_q <= S_FIN;
				S_FIN:  if (fin_fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			acc_q      <= ACC_W'(filter_q) * ACC_W'(FILTER_DIVISOR - 1) + ACC_W'(in_volt)
				+ ACC_W'(FILTER_DIVISOR / 2);
			taken_q    <= in_taken;
			cvalid_q   <= s_tuser[1];
			ext_q      <= s_tdata[16];
			full_q     <= s_tdata[17];
			filt_new_q <= in_volt;
		end
		if (state_q == S_FDIV) filt_new_q <= filt_prod[REC_SH +: VW];
		if (state_q == S_PSET) begin
			// clamps decide on their own, also when empty is not below full
			if (filt_new_q <= empty_level_q) cand_q <= '0;
			else cand_q <= blf_pkg::PCT_FULL;
		end
		if (state_q == S_PDIV && div_done) cand_q <= div_quo[PW-1:0];
	end

	always_comb begin
		diff = (cand_q >= disp_q) ? cand_q - disp_q : disp_q - cand_q;
		if (!primed_q || diff >= hyst_pct_q || cand_q == '0 || cand_q == blf_pkg::PCT_FULL)
			disp_next = cand_q;
		else
			disp_next = disp_q;
		consec_next = (consec_q != '1) ? consec_q + 1'b1 : consec_q;
		event_next = blf_pkg::EVENT_NONE;
		if (taken_q && cvalid_q && prev_ext_q != ext_q)
			event_next = ext_q ? blf_pkg::EVENT_START : blf_pkg::EVENT_END;
	end

	// commit state at the end of the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q    <= '0;
			disp_q      <= '0;
			primed_q    <= 1'b0;
			consec_q    <= '0;
			adc_err_q   <= '0;
			chg_err_q   <= '0;
			status_q    <= blf_pkg::STATUS_SEARCH;
			prev_ext_q  <= 1'b0;
			ext_held_q  <= 1'b0;
			full_held_q <= 1'b0;
		end else if (fin_fire) begin
			if (taken_q) begin
				filter_q <= filt_new_q;
				disp_q   <= disp_next;
				primed_q <= 1'b1;
				status_q <= blf_pkg::STATUS_READY;
				consec_q <= '0;
				if (cvalid_q) begin
					ext_held_q  <= ext_q;
					full_held_q <= full_q;
					prev_ext_q  <= ext_q;
				end else if (chg_err_q != '1) begin
					chg_err_q <= chg_err_q + 1'b1;
				end
			end else begin
				consec_q <= consec_next;
				if (adc_err_q != '1) adc_err_q <= adc_err_q + 1'b1;
				if (consec_next >= CW'(error_limit_q)) status_q <= blf_pkg::STATUS_ERROR;
			end
		end
	end

	// output register: hold until transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fin_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			m_tuser_q <= taken_q;
			if (taken_q) begin
				m_tdata_q <= {3'b000,
					(cvalid_q || chg_err_q == '1) ? chg_err_q : chg_err_q + 1'b1,
					adc_err_q,
					cvalid_q ? full_q : full_held_q,
					cvalid_q ? ext_q : ext_held_q,
					event_next,
					blf_pkg::STATUS_READY,
					disp_next,
					filt_new_q};
			end else begin
				m_tdata_q <= {3'b000,
					chg_err_q,
					(adc_err_q != '1) ? adc_err_q + 1'b1 : adc_err_q,
					full_held_q,
					ext_held_q,
					blf_pkg::EVENT_NONE,
					(consec_next >= CW'(error_limit_q)) ? blf_pkg::STATUS_ERROR : status_q,
					disp_q,
					filter_q};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== rtl/blf_divider.sv =====
// ----------------------------------------------------------------------------
// blf_divider: serial restoring divider
// One quotient bit per cycle; done pulses for one cycle when the quotient
// is complete. A divisor of zero is never requested.
// ----------------------------------------------------------------------------
module blf_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  blf_pkg::div_req_t           req,
	output logic                        done,
	output logic [blf_pkg::DIV_W-1:0]   quotient
);

	logic [blf_pkg::DVS_W-1:0] rem_q;
	logic [blf_pkg::DIV_W-1:0] quo_q;
	logic [blf_pkg::DVS_W-1:0] dvs_q;
	logic [blf_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [blf_pkg::DVS_W:0]   trial;
	logic                      fits;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[blf_pkg::DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= blf_pkg::CNT_W'(blf_pkg::DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= blf_pkg::DVS_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[blf_pkg::DVS_W-1:0];
			end
			quo_q <= {quo_q[blf_pkg::DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
